// ===== sv/pst_pkg.sv =====
package pst_pkg;

  // Command codes
  localparam logic [1:0] CMD_CREATE    = 2'd0;
  localparam logic [1:0] CMD_TERMINATE = 2'd1;
  localparam logic [1:0] CMD_SET_STATE = 2'd2;
  localparam logic [1:0] CMD_GET       = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // Run states
  localparam logic [1:0] RUN_READY      = 2'd0;
  localparam logic [1:0] RUN_RUNNING    = 2'd1;
  localparam logic [1:0] RUN_BLOCKED    = 2'd2;
  localparam logic [1:0] RUN_TERMINATED = 2'd3;

  // Field widths
  localparam int unsigned ID_W    = 16;
  localparam int unsigned COUNT_W = 5;
  localparam logic [ID_W-1:0]    ID_MAX    = 16'hFFFF;
  localparam logic [ID_W-1:0]    ID_FIRST  = 16'd1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // latch a new input beat, rewind the scan pointer
    logic rd;      // read one slot and advance the scan pointer
    logic commit;  // apply the update and load the result register
  } pst_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic hit;       // slot under compare is the one to act on
    logic last;      // slot under compare is the highest one
    logic out_free;  // result register can take a beat this cycle
  } pst_sts_t;

endpackage

// ===== sv/process_slot_table_top.sv =====
// Channel | Handshake               | Payload
// --------+-------------------------+-----------------------------------------------
// in      | in_valid_i / in_stall_o | cmd_i, target_id_i, new_state_i
// out     | out_valid_o/out_stall_i | status_o, result_id_o, entry_state_o,
//         |                         | active_count_o
//
// One command at a time: an accepted beat scans slots lowest first, one slot per
// cycle through the registered read port of the slot memory, and stops at the first
// hit, or at the last slot when no slot hits.
// Reset clears the active bits, the active count and sets the id counter to 1;
// the slot memories need no clearing since an inactive slot is never reported.
// The result register frees the scan for the next beat; a stalled result only
// holds the block in its final cycle until the register drains.
module process_slot_table_top #(
  parameter int unsigned SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [15:0] target_id_i,
  input  logic [1:0]  new_state_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [15:0] result_id_o,
  output logic [1:0]  entry_state_o,
  output logic [4:0]  active_count_o
);

  pst_pkg::pst_ctl_t ctl;
  pst_pkg::pst_sts_t sts;

  pst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  pst_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .cmd_i          (cmd_i),
    .target_id_i    (target_id_i),
    .new_state_i    (new_state_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .result_id_o    (result_id_o),
    .entry_state_o  (entry_state_o),
    .active_count_o (active_count_o)
  );

endmodule

// ===== sv/pst_ctrl.sv =====
module pst_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pst_pkg::pst_sts_t sts_i,
  output pst_pkg::pst_ctl_t ctl_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_PRIME  = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state_q, state_d;

  // Command decode
  always_comb begin
    ctl_o.load   = (state_q == S_IDLE) && in_valid_i;
    ctl_o.rd     = (state_q == S_PRIME) ||
                   ((state_q == S_SCAN) && !sts_i.hit && !sts_i.last);
    ctl_o.commit = (state_q == S_FINISH) && sts_i.out_free;
  end

  assign in_stall_o = (state_q != S_IDLE);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_PRIME;
      end
      S_PRIME: begin
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.hit || sts_i.last) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/pst_dp.sv =====
module pst_dp #(
  parameter int unsigned SLOTS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pst_pkg::pst_ctl_t ctl_i,
  output pst_pkg::pst_sts_t sts_o,
  input  logic [1:0]        cmd_i,
  input  logic [15:0]       target_id_i,
  input  logic [1:0]        new_state_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [1:0]        status_o,
  output logic [15:0]       result_id_o,
  output logic [1:0]        entry_state_o,
  output logic [4:0]        active_count_o
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  // Slot id and run state memories; the active bits decide whether an entry counts
  logic [pst_pkg::ID_W-1:0] mem_id [SLOTS];
  logic [1:0]               mem_st [SLOTS];

  logic [SLOTS-1:0]         act_q;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic [pst_pkg::ID_W-1:0] ctr_q;

  logic [1:0]               op_q, nst_q;
  logic [pst_pkg::ID_W-1:0] tgt_q;

  logic [IW-1:0]            ptr_q, rd_idx_q;
  logic [pst_pkg::ID_W-1:0] rd_id_q;
  logic [1:0]               rd_st_q;

  logic                     out_vld_q;
  logic [1:0]               status_q, entry_st_q;
  logic [pst_pkg::ID_W-1:0] res_id_q;
  logic [pst_pkg::COUNT_W-1:0] count_q;

  logic                     is_create, act_rd, hit;
  logic [1:0]               res_status, res_st;
  logic [pst_pkg::ID_W-1:0] res_id;
  logic [31:0]              cnt_w;
  logic [pst_pkg::COUNT_W-1:0] cnt_sat;

  // Compare stage: create looks for a free slot, the others for a matching id
  assign is_create = (op_q == pst_pkg::CMD_CREATE);
  assign act_rd    = act_q[rd_idx_q];
  assign hit       = is_create ? !act_rd : (act_rd && (rd_id_q == tgt_q));

  assign sts_o.hit      = hit;
  assign sts_o.last     = (rd_idx_q == LAST_IDX);
  assign sts_o.out_free = !out_vld_q || !out_stall_i;

  // Result and active count after the command
  always_comb begin
    res_status = pst_pkg::ST_OK;
    res_id     = '0;
    res_st     = pst_pkg::RUN_TERMINATED;
    cnt_d      = cnt_q;
    if (!hit) begin
      res_status = is_create ? pst_pkg::ST_FULL : pst_pkg::ST_NOT_FOUND;
    end else begin
      case (op_q)
        pst_pkg::CMD_CREATE: begin
          res_id = ctr_q;
          res_st = pst_pkg::RUN_READY;
          cnt_d  = cnt_q + CW'(1);
        end
        pst_pkg::CMD_TERMINATE: begin
          res_id = rd_id_q;
          res_st = pst_pkg::RUN_TERMINATED;
          cnt_d  = cnt_q - CW'(1);
        end
        pst_pkg::CMD_SET_STATE: begin
          res_id = rd_id_q;
          res_st = nst_q;
        end
        pst_pkg::CMD_GET: begin
          res_id = rd_id_q;
          res_st = rd_st_q;
        end
        default: begin
          res_id = rd_id_q;
        end
      endcase
    end
    cnt_w   = 32'(cnt_d);
    cnt_sat = (cnt_w > 32'(pst_pkg::COUNT_MAX)) ? pst_pkg::COUNT_MAX
                                                : cnt_w[pst_pkg::COUNT_W-1:0];
  end

  // Input beat capture and scan pointer
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      op_q  <= cmd_i;
      tgt_q <= target_id_i;
      nst_q <= new_state_i;
      ptr_q <= '0;
    end else if (ctl_i.rd) begin
      ptr_q <= ptr_q + IW'(1);
    end
  end

  // Memory read and write ports
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd) begin
      rd_id_q  <= mem_id[ptr_q];
      rd_st_q  <= mem_st[ptr_q];
      rd_idx_q <= ptr_q;
    end
    if (ctl_i.commit && hit) begin
      case (op_q)
        pst_pkg::CMD_CREATE: begin
          mem_id[rd_idx_q] <= ctr_q;
          mem_st[rd_idx_q] <= pst_pkg::RUN_READY;
        end
        pst_pkg::CMD_TERMINATE: begin
          mem_st[rd_idx_q] <= pst_pkg::RUN_TERMINATED;
        end
        pst_pkg::CMD_SET_STATE: begin
          mem_st[rd_idx_q] <= nst_q;
        end
        default: begin
        end
      endcase
    end
  end

  // Active bits, active count and id counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= '0;
      cnt_q <= '0;
      ctr_q <= pst_pkg::ID_FIRST;
    end else if (ctl_i.commit && hit) begin
      cnt_q <= cnt_d;
      if (is_create) begin
        act_q[rd_idx_q] <= 1'b1;
        ctr_q <= (ctr_q == pst_pkg::ID_MAX) ? pst_pkg::ID_FIRST
                                            : ctr_q + pst_pkg::ID_W'(1);
      end else if (op_q == pst_pkg::CMD_TERMINATE) begin
        act_q[rd_idx_q] <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ctl_i.commit) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.commit) begin
      status_q   <= res_status;
      res_id_q   <= res_id;
      entry_st_q <= res_st;
      count_q    <= cnt_sat;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign status_o       = status_q;
  assign result_id_o    = res_id_q;
  assign entry_state_o  = entry_st_q;
  assign active_count_o = count_q;

  // Checks
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.commit |-> sts_o.out_free)
    else $error("commit while result register is occupied");

  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.commit |=> out_vld_q)
    else $error("result beat lost after commit");

  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) == 32'($countones(act_q)))
    else $error("active count out of step with active bits");

  a_ctr_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctr_q != '0)
    else $error("id counter reached zero");

endmodule

// ===== dv/tb_process_slot_table_top.sv =====
module tb_process_slot_table_top;

  localparam int          SLOTS       = 16;
  localparam int          HELD_SLOTS  = 3;
  localparam int          HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 200_000;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] id;
    logic [1:0]  state;
    logic [4:0]  count;
  } table_result_t;

  // Shadow of the slot table plus the results still owed by the block
  class slot_table_checker;
    bit            active[SLOTS];
    logic [15:0]   ids[SLOTS];
    logic [1:0]    run[SLOTS];
    logic [15:0]   next_id;
    table_result_t awaited_results[$];
    int            errors;
    int            beats_seen;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        active[i] = 1'b0;
        ids[i]    = '0;
        run[i]    = pst_pkg::RUN_TERMINATED;
      end
      next_id    = pst_pkg::ID_FIRST;
      errors     = 0;
      beats_seen = 0;
    endfunction

    function int live_total();
      int n;
      n = 0;
      for (int i = 0; i < SLOTS; i++) if (active[i]) n++;
      return n;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    // Random identifier of a live slot, or any value when the table is empty
    function logic [15:0] pick_live_id();
      int live[$];
      for (int i = 0; i < SLOTS; i++) if (active[i]) live.push_back(i);
      if (live.size() == 0) return 16'($urandom);
      return ids[live[$urandom_range(live.size() - 1)]];
    endfunction

    // Apply one accepted command to the shadow table and queue its result
    function void apply_command(logic [1:0] cmd, logic [15:0] tid, logic [1:0] nstate);
      table_result_t r;
      int            slot;
      int            n;
      r.status = pst_pkg::ST_OK;
      r.id     = '0;
      r.state  = pst_pkg::RUN_TERMINATED;
      slot     = -1;
      if (cmd == pst_pkg::CMD_CREATE) begin
        for (int i = 0; i < SLOTS; i++) if (!active[i] && slot < 0) slot = i;
        if (slot < 0) begin
          r.status = pst_pkg::ST_FULL;
        end else begin
          active[slot] = 1'b1;
          ids[slot]    = next_id;
          run[slot]    = pst_pkg::RUN_READY;
          r.id         = next_id;
          r.state      = pst_pkg::RUN_READY;
          if (next_id == pst_pkg::ID_MAX) begin
            next_id = pst_pkg::ID_FIRST;
          end else begin
            next_id = next_id + 16'd1;
          end
        end
      end else begin
        // lowest live slot wins when identifiers repeat after a wrap
        for (int i = 0; i < SLOTS; i++) if (active[i] && ids[i] == tid && slot < 0) slot = i;
        if (slot < 0) begin
          r.status = pst_pkg::ST_NOT_FOUND;
        end else begin
          if (cmd == pst_pkg::CMD_TERMINATE) begin
            active[slot] = 1'b0;
            run[slot]    = pst_pkg::RUN_TERMINATED;
          end else if (cmd == pst_pkg::CMD_SET_STATE) begin
            run[slot] = nstate;
          end
          r.id    = ids[slot];
          r.state = run[slot];
        end
      end
      n       = live_total();
      r.count = (n > int'(pst_pkg::COUNT_MAX)) ? pst_pkg::COUNT_MAX : 5'(n);
      awaited_results.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR: beat %0d: %s", beats_seen, msg);
    endtask

    task check_result(table_result_t got);
      table_result_t want;
      beats_seen++;
      if (awaited_results.size() == 0) begin
        report($sformatf("unexpected result status=%0d id=%0d state=%0d count=%0d",
                         got.status, got.id, got.state, got.count));
        return;
      end
      want = awaited_results.pop_front();
      if (got.status !== want.status || got.id !== want.id ||
          got.state !== want.state || got.count !== want.count)
        report($sformatf("status %0d/%0d id %0d/%0d state %0d/%0d count %0d/%0d (got/exp)",
                         got.status, want.status, got.id, want.id,
                         got.state, want.state, got.count, want.count));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  cmd_i;
  logic [15:0] target_id_i;
  logic [1:0]  new_state_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  status_o;
  logic [15:0] result_id_o;
  logic [1:0]  entry_state_o;
  logic [4:0]  active_count_o;

  slot_table_checker sb = new();
  bit                fast_mode    = 1'b0;
  bit                hold_off_req = 1'b0;
  int unsigned       cycle_count;

  process_slot_table_top #(
    .SLOTS(SLOTS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .target_id_i   (target_id_i),
    .new_state_i   (new_state_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .result_id_o   (result_id_o),
    .entry_state_o (entry_state_o),
    .active_count_o(active_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("process_slot_table_top: mismatch");
    $finish;
  end

  // Result side: sample at the falling edge, decide the next stall at the rising edge
  initial begin : result_side
    int            hold_left;
    bit            hold_done;
    table_result_t got;
    hold_left   = 0;
    hold_done   = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got.status = status_o;
        got.id     = result_id_o;
        got.state  = entry_state_o;
        got.count  = active_count_o;
        sb.check_result(got);
      end
      @(posedge clk_i);
      if (hold_off_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (fast_mode) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < 37);
      end
    end
  end

  // Offer one command beat; valid stays high on return
  task automatic send_beat(input logic [1:0] cmd, input logic [15:0] tid,
                           input logic [1:0] nstate);
    bit taken;
    while (!fast_mode && $urandom_range(99) < 37) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= cmd;
    target_id_i <= tid;
    new_state_i <= nstate;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    sb.apply_command(cmd, tid, nstate);
  endtask

  task automatic random_beat();
    int          pick;
    logic [1:0]  cmd;
    logic [15:0] tid;
    pick = $urandom_range(99);
    if (pick < 30)      cmd = pst_pkg::CMD_CREATE;
    else if (pick < 55) cmd = pst_pkg::CMD_TERMINATE;
    else if (pick < 80) cmd = pst_pkg::CMD_SET_STATE;
    else                cmd = pst_pkg::CMD_GET;
    pick = $urandom_range(99);
    if (pick < 75)      tid = sb.pick_live_id();
    else if (pick < 85) tid = 16'($urandom_range(40));
    else                tid = 16'($urandom_range(16'hFFFF));
    send_beat(cmd, tid, 2'($urandom_range(3)));
  endtask

  initial begin : stimulus
    in_valid_i  = 1'b0;
    cmd_i       = pst_pkg::CMD_GET;
    target_id_i = '0;
    new_state_i = pst_pkg::RUN_READY;
    rst_ni      = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: lookups on an empty table, then each command on live slots
    send_beat(pst_pkg::CMD_GET,       16'd0,    pst_pkg::RUN_READY);
    send_beat(pst_pkg::CMD_TERMINATE, 16'hFFFF, pst_pkg::RUN_TERMINATED);
    send_beat(pst_pkg::CMD_SET_STATE, 16'd5,    pst_pkg::RUN_RUNNING);
    send_beat(pst_pkg::CMD_CREATE,    16'hFFFF, pst_pkg::RUN_TERMINATED);
    send_beat(pst_pkg::CMD_CREATE,    16'd0,    pst_pkg::RUN_READY);
    send_beat(pst_pkg::CMD_SET_STATE, 16'd1,    pst_pkg::RUN_RUNNING);
    send_beat(pst_pkg::CMD_SET_STATE, 16'd2,    pst_pkg::RUN_BLOCKED);
    // set to terminated keeps the slot live
    send_beat(pst_pkg::CMD_SET_STATE, 16'd1,    pst_pkg::RUN_TERMINATED);
    send_beat(pst_pkg::CMD_GET,       16'd1,    pst_pkg::RUN_BLOCKED);
    send_beat(pst_pkg::CMD_GET,       16'd0,    pst_pkg::RUN_READY);
    send_beat(pst_pkg::CMD_TERMINATE, 16'd1,    pst_pkg::RUN_READY);
    send_beat(pst_pkg::CMD_GET,       16'd1,    pst_pkg::RUN_READY);
    send_beat(pst_pkg::CMD_CREATE,    16'd1,    pst_pkg::RUN_RUNNING);
    send_beat(pst_pkg::CMD_SET_STATE, 16'd3,    pst_pkg::RUN_READY);
    send_beat(pst_pkg::CMD_GET,       16'd3,    pst_pkg::RUN_TERMINATED);

    // Fill the table, try one create too many, keep only the top slots live
    while (sb.live_total() < SLOTS)
      send_beat(pst_pkg::CMD_CREATE, 16'($urandom), 2'($urandom));
    send_beat(pst_pkg::CMD_CREATE, 16'($urandom), 2'($urandom));
    for (int i = 0; i < SLOTS - HELD_SLOTS; i++)
      send_beat(pst_pkg::CMD_TERMINATE, sb.ids[i], pst_pkg::RUN_READY);

    // Random traffic; one stretch with no idling, then a long result hold-off
    for (int n = 0; n < 900; n++) begin
      if (n == 100) fast_mode = 1'b1;
      if (n == 300) fast_mode = 1'b0;
      if (n == 450) hold_off_req = 1'b1;
      random_beat();
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SLOTS + 8) @(posedge clk_i);
    if (sb.errors == 0)
      $display("process_slot_table_top: match");
    else
      $display("process_slot_table_top: mismatch");
    $finish;
  end

endmodule
